[rtl/core/araf_pkg.sv]
`default_nettype none

package araf_pkg;

  localparam int COORD_BITS   = 16;
  localparam int SRC_BITS     = 16;
  localparam int PROD_BITS    = COORD_BITS + SRC_BITS;
  localparam int CMP_BITS     = (COORD_BITS > SRC_BITS) ? COORD_BITS : SRC_BITS;
  localparam int CFG_IDX_BITS = 3;
  localparam int QUEUE_DEPTH  = 2;
  localparam int DIV_STAGES   = COORD_BITS;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_DST_LEFT    = 3'd0,
    REG_DST_TOP     = 3'd1,
    REG_DST_RIGHT   = 3'd2,
    REG_DST_BOTTOM  = 3'd3,
    REG_CENTER_MODE = 3'd4,
    REG_EXPAND_MODE = 3'd5
  } cfg_reg_e;

  typedef logic        [COORD_BITS-1:0] coord_t;
  typedef logic signed [COORD_BITS-1:0] scoord_t;
  typedef logic        [SRC_BITS-1:0]   src_t;
  typedef logic        [PROD_BITS-1:0]  prod_t;

  // one classified fit: primary side is the longer source side
  typedef struct packed {
    logic    swap;    // primary side is the height
    coord_t  p_lim;   // primary extent after source limit
    coord_t  d_p;     // destination extent along primary side
    coord_t  d_s;     // destination extent along secondary side
    src_t    p_src;
    src_t    s_src;
    scoord_t org_x;
    scoord_t org_y;
    logic    center;
    logic    empty;
  } job_t;

endpackage

`default_nettype wire

[rtl/core/araf_front.sv]
`default_nettype none

module araf_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [araf_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [araf_pkg::COORD_BITS-1:0]      cfg_wdata_i,
  input  logic [araf_pkg::SRC_BITS-1:0]        src_width_i,
  input  logic [araf_pkg::SRC_BITS-1:0]        src_height_i,
  output araf_pkg::job_t                       job_o
);
  import araf_pkg::*;

  scoord_t dst_left_q, dst_top_q, dst_right_q, dst_bottom_q;
  logic    center_q, expand_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dst_left_q   <= '0;
      dst_top_q    <= '0;
      dst_right_q  <= '0;
      dst_bottom_q <= '0;
      center_q     <= 1'b0;
      expand_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_DST_LEFT:    dst_left_q   <= scoord_t'(cfg_wdata_i);
        REG_DST_TOP:     dst_top_q    <= scoord_t'(cfg_wdata_i);
        REG_DST_RIGHT:   dst_right_q  <= scoord_t'(cfg_wdata_i);
        REG_DST_BOTTOM:  dst_bottom_q <= scoord_t'(cfg_wdata_i);
        REG_CENTER_MODE: center_q     <= cfg_wdata_i[0];
        REG_EXPAND_MODE: expand_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  scoord_t lo_x, hi_x, lo_y, hi_y;
  coord_t  dw, dh, d_p, d_s;
  src_t    p_src, s_src;
  logic    swap;
  logic [CMP_BITS-1:0] dp_x, ps_x;

  always_comb begin
    lo_x  = (dst_left_q > dst_right_q) ? dst_right_q : dst_left_q;
    hi_x  = (dst_left_q > dst_right_q) ? dst_left_q  : dst_right_q;
    lo_y  = (dst_top_q > dst_bottom_q) ? dst_bottom_q : dst_top_q;
    hi_y  = (dst_top_q > dst_bottom_q) ? dst_top_q    : dst_bottom_q;
    dw    = coord_t'(hi_x - lo_x);
    dh    = coord_t'(hi_y - lo_y);
    swap  = src_width_i < src_height_i;
    p_src = swap ? src_height_i : src_width_i;
    s_src = swap ? src_width_i  : src_height_i;
    d_p   = swap ? dh : dw;
    d_s   = swap ? dw : dh;
    dp_x  = CMP_BITS'(d_p);
    ps_x  = CMP_BITS'(p_src);

    job_o.swap   = swap;
    job_o.p_lim  = (expand_q || (dp_x <= ps_x)) ? d_p : COORD_BITS'(ps_x);
    job_o.d_p    = d_p;
    job_o.d_s    = d_s;
    job_o.p_src  = p_src;
    job_o.s_src  = s_src;
    job_o.org_x  = lo_x;
    job_o.org_y  = lo_y;
    job_o.center = center_q;
    job_o.empty  = (src_width_i == '0) && (src_height_i == '0);
  end

endmodule

`default_nettype wire

[rtl/core/araf_fifo.sv]
`default_nettype none

module araf_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  araf_pkg::job_t data_i,
  input  logic           pop_i,
  output araf_pkg::job_t data_o,
  output logic           valid_o,
  output logic           full_o
);
  import araf_pkg::*;

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

  job_t                mem_q [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PTR_BITS:0]   count_q, count_d;
  logic                do_push, do_pop;

  assign valid_o = count_q != '0;
  assign full_o  = count_q == (PTR_BITS+1)'(QUEUE_DEPTH);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (PTR_BITS+1)'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

`default_nettype wire

[rtl/core/araf_div.sv]
`default_nettype none

// quotient of num/den, one quotient bit per stage; valid while the
// quotient fits COORD_BITS; zero divisor gives zero
module araf_div (
  input  logic                               clk_i,
  input  logic [araf_pkg::PROD_BITS-1:0]     num_i,
  input  logic [araf_pkg::SRC_BITS-1:0]      den_i,
  output logic [araf_pkg::COORD_BITS-1:0]    quo_o
);
  import araf_pkg::*;

  logic [SRC_BITS-1:0]   rem_q  [DIV_STAGES-1];
  logic [COORD_BITS-1:0] word_q [DIV_STAGES];
  logic [SRC_BITS-1:0]   den_q  [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [SRC_BITS-1:0]   rem_in;
    logic [COORD_BITS-1:0] word_in;
    logic [SRC_BITS-1:0]   den_in;
    logic [SRC_BITS:0]     trial;
    logic                  ge;

    if (k == 0) begin : g_first
      assign rem_in  = num_i[PROD_BITS-1:COORD_BITS];
      assign word_in = num_i[COORD_BITS-1:0];
      assign den_in  = den_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign word_in = word_q[k-1];
      assign den_in  = den_q[k-1];
    end

    assign trial = {rem_in, word_in[COORD_BITS-1]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      word_q[k] <= {word_in[COORD_BITS-2:0], ge};
      den_q[k]  <= den_in;
    end

    if (k < DIV_STAGES-1) begin : g_rem
      always_ff @(posedge clk_i) begin
        rem_q[k] <= ge ? SRC_BITS'(trial - {1'b0, den_in}) : trial[SRC_BITS-1:0];
      end
    end
  end

  assign quo_o = (den_q[DIV_STAGES-1] == '0) ? '0 : word_q[DIV_STAGES-1];

endmodule

`default_nettype wire

[rtl/core/araf_back.sv]
`default_nettype none

module araf_back (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  input  araf_pkg::job_t                        job_i,
  output logic                                  done_o,
  output logic signed [araf_pkg::COORD_BITS-1:0] fit_left_o,
  output logic signed [araf_pkg::COORD_BITS-1:0] fit_top_o,
  output logic signed [araf_pkg::COORD_BITS-1:0] fit_right_o,
  output logic signed [araf_pkg::COORD_BITS-1:0] fit_bottom_o,
  output logic                                  empty_o
);
  import araf_pkg::*;

  // multiply stage
  logic  m_vld_q;
  job_t  m_job_q;
  prod_t prod1_q, prod2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else begin
      m_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    m_job_q <= job_i;
    prod1_q <= PROD_BITS'(job_i.p_lim) * PROD_BITS'(job_i.s_src);
    prod2_q <= PROD_BITS'(job_i.d_s) * PROD_BITS'(job_i.p_src);
  end

  // both fits divide in parallel; selection picks one later
  coord_t q1, q2;

  araf_div u_div_fit (
    .clk_i (clk_i),
    .num_i (prod1_q),
    .den_i (m_job_q.p_src),
    .quo_o (q1)
  );

  araf_div u_div_refit (
    .clk_i (clk_i),
    .num_i (prod2_q),
    .den_i (m_job_q.s_src),
    .quo_o (q2)
  );

  logic side_vld_q [DIV_STAGES];
  job_t side_q     [DIV_STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        side_vld_q[k] <= 1'b0;
      end
    end else begin
      side_vld_q[0] <= m_vld_q;
      for (int k = 1; k < DIV_STAGES; k++) begin
        side_vld_q[k] <= side_vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= m_job_q;
    for (int k = 1; k < DIV_STAGES; k++) begin
      side_q[k] <= side_q[k-1];
    end
  end

  // select stage
  job_t    j;
  logic    over;
  coord_t  pri, sec;
  logic    s_vld_q;
  coord_t  rw_q, rh_q, dw_q, dh_q;
  scoord_t org_x_q, org_y_q;
  logic    center_q, empty_q;

  always_comb begin
    j    = side_q[DIV_STAGES-1];
    over = q1 > j.d_s;
    pri  = over ? q2 : j.p_lim;
    sec  = over ? j.d_s : q1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_vld_q <= 1'b0;
    end else begin
      s_vld_q <= side_vld_q[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    rw_q     <= j.swap ? sec : pri;
    rh_q     <= j.swap ? pri : sec;
    dw_q     <= j.swap ? j.d_s : j.d_p;
    dh_q     <= j.swap ? j.d_p : j.d_s;
    org_x_q  <= j.org_x;
    org_y_q  <= j.org_y;
    center_q <= j.center;
    empty_q  <= j.empty;
  end

  // placement stage
  coord_t  off_x, off_y, x0, y0;
  logic    done_q;
  scoord_t left_q, top_q, right_q, bottom_q;
  logic    out_empty_q;

  always_comb begin
    off_x = center_q ? coord_t'((dw_q - rw_q) >> 1) : '0;
    off_y = center_q ? coord_t'((dh_q - rh_q) >> 1) : '0;
    x0    = coord_t'(org_x_q) + off_x;
    y0    = coord_t'(org_y_q) + off_y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    left_q      <= scoord_t'(x0);
    top_q       <= scoord_t'(y0);
    right_q     <= scoord_t'(x0 + rw_q);
    bottom_q    <= scoord_t'(y0 + rh_q);
    out_empty_q <= empty_q;
  end

  assign done_o       = done_q;
  assign fit_left_o   = left_q;
  assign fit_top_o    = top_q;
  assign fit_right_o  = right_q;
  assign fit_bottom_o = bottom_q;
  assign empty_o      = out_empty_q;

  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> ##(DIV_STAGES+3) done_o)
    else $error("result strobe missing after fixed latency");

  a_fit_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_vld_q |-> (rw_q <= dw_q) && (rh_q <= dh_q))
    else $error("fitted extent exceeds destination");

endmodule

`default_nettype wire

[rtl/core/aspect_ratio_fit.sv]
// A start transfer passes the front queue, the multiply stage, the divider pipeline (one quotient bit
// per stage), the select stage and the placement stage before the done strobe.
// Throughput: one fit per cycle; busy rises only if the front queue fills.
// Results appear on done_o for one cycle and cannot be stalled by the receiver.
// Reset (rst_ni low, asynchronous) zeroes all config registers and empties the pipe.
`default_nettype none

module aspect_ratio_fit (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [araf_pkg::CFG_IDX_BITS-1:0]      cfg_idx_i,
  input  logic [araf_pkg::COORD_BITS-1:0]        cfg_wdata_i,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [araf_pkg::SRC_BITS-1:0]          src_width_i,
  input  logic [araf_pkg::SRC_BITS-1:0]          src_height_i,
  output logic                                   done_o,
  output logic signed [araf_pkg::COORD_BITS-1:0] fit_left_o,
  output logic signed [araf_pkg::COORD_BITS-1:0] fit_top_o,
  output logic signed [araf_pkg::COORD_BITS-1:0] fit_right_o,
  output logic signed [araf_pkg::COORD_BITS-1:0] fit_bottom_o,
  output logic                                   empty_source_o
);
  import araf_pkg::*;

  job_t front_job, back_job;
  logic q_valid, q_full, push;

  assign busy = q_full;
  assign push = start && !q_full;

  araf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .src_width_i  (src_width_i),
    .src_height_i (src_height_i),
    .job_o        (front_job)
  );

  araf_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_job),
    .pop_i   (q_valid),
    .data_o  (back_job),
    .valid_o (q_valid),
    .full_o  (q_full)
  );

  araf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (q_valid),
    .job_i        (back_job),
    .done_o       (done_o),
    .fit_left_o   (fit_left_o),
    .fit_top_o    (fit_top_o),
    .fit_right_o  (fit_right_o),
    .fit_bottom_o (fit_bottom_o),
    .empty_o      (empty_source_o)
  );

  // empty source: height is always zero; width stays open in expand mode
  a_empty_is_flat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && empty_source_o |-> (fit_top_o == fit_bottom_o))
    else $error("empty source gave nonzero height");

endmodule

`default_nettype wire

[tb/aspect_ratio_fit_tb.sv]
`default_nettype none

module aspect_ratio_fit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import araf_pkg::*;

  localparam int LATENCY     = COORD_BITS + 4;
  localparam int STALL_LIMIT = 2000;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 88;

  typedef struct packed {
    src_t w;
    src_t h;
  } src_size_t;

  typedef struct packed {
    scoord_t left;
    scoord_t top;
    scoord_t right;
    scoord_t bottom;
    logic    empty;
  } fit_rect_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      cfg_we_i    = 1'b0;
  cfg_reg_e  cfg_idx_i   = REG_DST_LEFT;
  coord_t    cfg_wdata_i = '0;
  logic      start       = 1'b0;
  logic      busy;
  src_t      src_width_i  = '0;
  src_t      src_height_i = '0;
  logic      done_o;
  scoord_t   fit_left_o;
  scoord_t   fit_top_o;
  scoord_t   fit_right_o;
  scoord_t   fit_bottom_o;
  logic      empty_source_o;

  aspect_ratio_fit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .start         (start),
    .busy          (busy),
    .src_width_i   (src_width_i),
    .src_height_i  (src_height_i),
    .done_o        (done_o),
    .fit_left_o    (fit_left_o),
    .fit_top_o     (fit_top_o),
    .fit_right_o   (fit_right_o),
    .fit_bottom_o  (fit_bottom_o),
    .empty_source_o(empty_source_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow copy of the destination setup
  scoord_t dst_l = '0, dst_t = '0, dst_r = '0, dst_b = '0;
  logic    center_on = 1'b0, expand_on = 1'b0;

  src_size_t src_q[$];
  fit_rect_t fit_q[$];
  int        sizes_queued  = 0;
  int        sizes_taken   = 0;
  int        fits_checked  = 0;
  int        fit_errors    = 0;
  int        dest_settings = 0;
  int        idle_cycles   = 0;
  int        gap_left      = 0;
  bit        gaps_on       = 1'b0;

  function automatic fit_rect_t fit_rect(src_size_t s);
    int        l, r, t, b, tmp, x0, y0;
    prod_t     dw, dh, rw, rh;
    fit_rect_t f;
    l = dst_l;
    r = dst_r;
    t = dst_t;
    b = dst_b;
    if (l > r) begin
      tmp = l; l = r; r = tmp;
    end
    if (t > b) begin
      tmp = t; t = b; b = tmp;
    end
    dw = prod_t'(r - l);
    dh = prod_t'(b - t);
    if (s.w >= s.h) begin
      rw = expand_on ? dw : ((dw < prod_t'(s.w)) ? dw : prod_t'(s.w));
      rh = (s.w != 0) ? (rw * s.h) / s.w : '0;
      if (rh > dh) begin
        rh = dh;
        rw = (s.h != 0) ? (rh * s.w) / s.h : '0;
      end
    end else begin
      rh = expand_on ? dh : ((dh < prod_t'(s.h)) ? dh : prod_t'(s.h));
      rw = (s.h != 0) ? (rh * s.w) / s.h : '0;
      if (rw > dw) begin
        rw = dw;
        rh = (s.w != 0) ? (rw * s.h) / s.w : '0;
      end
    end
    x0 = l;
    y0 = t;
    if (center_on) begin
      x0 += int'((dw - rw) >> 1);
      y0 += int'((dh - rh) >> 1);
    end
    f.left   = scoord_t'(x0);
    f.top    = scoord_t'(y0);
    f.right  = scoord_t'(x0 + int'(rw));
    f.bottom = scoord_t'(y0 + int'(rh));
    f.empty  = (s.w == 0) && (s.h == 0);
    return f;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic src_size_t rand_size();
    src_size_t s;
    int        r;
    r = $urandom_range(0, 99);
    s.w = src_t'($urandom);
    s.h = src_t'($urandom);
    if (r < 30) begin
    end else if (r < 55) begin
      s.w = src_t'($urandom_range(0, 1000));
      s.h = src_t'($urandom_range(0, 1000));
    end else if (r < 65) begin
      if ($urandom_range(0, 1)) s.w = '0;
      else s.h = '0;
    end else if (r < 75) begin
      s.h = s.w;
    end else if (r < 85) begin
      s.w = $urandom_range(0, 1) ? src_t'(16'hFFFF - $urandom_range(0, 2))
                                 : src_t'($urandom_range(0, 2));
      s.h = $urandom_range(0, 1) ? src_t'(16'hFFFF - $urandom_range(0, 2))
                                 : src_t'($urandom_range(0, 2));
    end else begin
      s.w = src_t'($urandom_range(1, 4000));
      s.h = src_t'((int'(s.w) * $urandom_range(1, 16)) / $urandom_range(1, 16));
    end
    return s;
  endfunction

  // driver: one size per transfer, held while busy
  always @(posedge clk_i) begin : drive
    src_size_t cur;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        cur.w = src_width_i;
        cur.h = src_height_i;
        fit_q.push_back(fit_rect(cur));
        sizes_taken++;
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (src_q.size() != 0) begin
          cur = src_q.pop_front();
          start        <= 1'b1;
          src_width_i  <= cur.w;
          src_height_i <= cur.h;
          gap_left = pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin : check
    fit_rect_t got, want;
    if (rst_ni && done_o) begin
      got = '{fit_left_o, fit_top_o, fit_right_o, fit_bottom_o, empty_source_o};
      if (fit_q.size() == 0) begin
        fit_errors++;
        if (fit_errors <= 10)
          $display("unexpected fit %0d %0d %0d %0d empty=%0b", got.left, got.top,
                   got.right, got.bottom, got.empty);
      end else begin
        want = fit_q.pop_front();
        fits_checked++;
        if (got.left !== want.left || got.top !== want.top || got.right !== want.right ||
            got.bottom !== want.bottom || got.empty !== want.empty) begin
          fit_errors++;
          if (fit_errors <= 10)
            $display("fit mismatch: expected %0d %0d %0d %0d empty=%0b, got %0d %0d %0d %0d empty=%0b",
                     want.left, want.top, want.right, want.bottom, want.empty,
                     got.left, got.top, got.right, got.bottom, got.empty);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || cfg_we_i) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
    $display("status: fail");
    $finish;
  end

  task automatic write_reg(cfg_reg_e idx, coord_t val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_DST_LEFT:    dst_l = val;
      REG_DST_TOP:     dst_t = val;
      REG_DST_RIGHT:   dst_r = val;
      REG_DST_BOTTOM:  dst_b = val;
      REG_CENTER_MODE: center_on = val[0];
      REG_EXPAND_MODE: expand_on = val[0];
      default: ;
    endcase
  endtask

  task automatic set_dest(scoord_t l, scoord_t t, scoord_t r, scoord_t b,
                          coord_t center_val, coord_t expand_val);
    write_reg(REG_DST_LEFT, l);
    write_reg(REG_DST_TOP, t);
    write_reg(REG_DST_RIGHT, r);
    write_reg(REG_DST_BOTTOM, b);
    write_reg(REG_CENTER_MODE, center_val);
    write_reg(REG_EXPAND_MODE, expand_val);
    dest_settings++;
    @(negedge clk_i);
  endtask

  task automatic pick_span(output scoord_t a, output scoord_t z);
    scoord_t tmp;
    case ($urandom_range(0, 3))
      0: begin
        a = scoord_t'($urandom);
        z = scoord_t'($urandom);
      end
      1: begin
        a = 16'sh8000;
        z = 16'sh7FFF;
      end
      2: begin
        a = scoord_t'(int'($urandom_range(0, 60000)) - 30000);
        z = a + scoord_t'($urandom_range(0, 300));
      end
      default: begin
        a = scoord_t'($urandom);
        z = a;
      end
    endcase
    if ($urandom_range(0, 1)) begin
      tmp = a; a = z; z = tmp;
    end
  endtask

  task automatic push_size(src_size_t s);
    src_q.push_back(s);
    sizes_queued++;
  endtask

  // sender holds off until every expected fit has come back
  task automatic drain();
    while (sizes_taken != sizes_queued || fit_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    src_size_t dir_sizes[$];
    scoord_t   el, et, er, eb;
    int        ph, i;
    dir_sizes = '{'{16'd0, 16'd0}, '{16'd0, 16'd5}, '{16'd9, 16'd0},
                  '{16'hFFFF, 16'hFFFF}, '{16'hFFFF, 16'd1}, '{16'd1, 16'hFFFF},
                  '{16'd1920, 16'd1080}, '{16'd1080, 16'd1920}, '{16'd0, 16'hFFFF},
                  '{16'hFFFF, 16'd0}, '{16'd300, 16'd300}};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset setup: zero-size destination
    push_size('{16'd0, 16'd0});
    push_size('{16'd7, 16'd3});
    drain();

    set_dest(-16'sd100, -16'sd50, 16'sd540, 16'sd430, 16'd0, 16'd0);
    foreach (dir_sizes[k]) push_size(dir_sizes[k]);
    drain();

    // swapped edges, centered, expand
    gaps_on = 1'b1;
    set_dest(16'sd300, 16'sd200, -16'sd20, 16'sd10, 16'd1, 16'd1);
    foreach (dir_sizes[k]) push_size(dir_sizes[k]);
    drain();

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      pick_span(el, er);
      pick_span(et, eb);
      if (ph == 0) begin
        el = 16'sh8000; et = 16'sh8000; er = 16'sh7FFF; eb = 16'sh7FFF;
      end else if (ph == 1) begin
        el = 16'sh7FFF; et = 16'sh7FFF; er = 16'sh8000; eb = 16'sh8000;
      end
      gaps_on = (ph != 2);
      set_dest(el, et, er, eb, coord_t'($urandom), coord_t'($urandom));
      for (i = 0; i < PHASE_ITEMS; i++) push_size(rand_size());
      drain();
    end

    repeat (LATENCY + 8) @(negedge clk_i);
    $display("checked %0d fits from %0d source sizes over %0d destination setups",
             fits_checked, sizes_taken, dest_settings);
    $display("mismatches: %0d, fits still outstanding: %0d", fit_errors, fit_q.size());
    if (fit_errors == 0 && fit_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
